[rtl/core/ffd_pkg.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ffd_pkg
// Shared types and constants of the fractional feedback delay: sample width,
// register widths and indexes, and the request and response beat layouts.
// -----------------------------------------------------------------------------
package ffd_pkg;

   localparam int SAMPLE_W      = 16;
   localparam int DEPTH_DEFAULT = 32768;
   localparam int WHOLE_W       = 15;
   localparam int COEF_W        = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_ADDR_W    = 2;

   // Unity gain in unsigned 1.15.
   localparam logic [COEF_W-1:0] UNITY = 16'd32768;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DELAY_WHOLE   = 2'd0,
      CSR_DELAY_FRAC    = 2'd1,
      CSR_MIX_LEVEL     = 2'd2,
      CSR_FEEDBACK_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       block_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       block_end_out;
   } rsp_type;

endpackage
`default_nettype wire

[rtl/core/fractional_feedback_delay.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// fractional_feedback_delay
// Mono feedback delay line with linear interpolation between two taps.
// -----------------------------------------------------------------------------
// Each accepted sample beat reads two neighboring entries of a circular store
// at the write position minus the whole delay, blends them by the fractional
// delay, writes the input plus the feedback-scaled delayed sample (saturated)
// back at the write position and emits the dry/wet mix (saturated). A whole
// delay of zero (modulo DEPTH) passes the input straight through and leaves
// the store untouched. An accepted sample steps through S_RB, S_MB, S_FB,
// S_WR, S_MX and S_OUT (straight to S_OUT in pass-through); S_OUT loads the
// response register once it is free or being drained, and the next request
// beat can be taken in the cycle after that. The sequence is set by the
// single read port of the store (two tap reads in turn) and the one shared
// 16x18 multiplier, which handles the interpolation, feedback and mix
// products one after the other. One sample is in flight at a time; the next
// request beat is taken while the previous response still waits at the
// output. After reset the store is swept to zero, one entry per cycle;
// request beats are held off during that time, while register writes are
// taken as usual. A write of the whole delay starts a remainder computation,
// during which request beats are also held off.
// -----------------------------------------------------------------------------
module fractional_feedback_delay #(
   parameter int DEPTH = ffd_pkg::DEPTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Request channel.
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire ffd_pkg::req_type                   req_payload,
   // Response channel.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output ffd_pkg::rsp_type                        rsp_payload,
   // Register write port.
   input  wire logic                               csr_wen,
   input  wire logic [ffd_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [ffd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = ffd_pkg::SAMPLE_W;
   // Product and accumulator width: a sample times an 18-bit signed factor.
   localparam int PW = SW + 18;
   localparam int SUMW = SW + 3;

   localparam logic signed [SUMW-1:0] SAT_MAX = SUMW'((1 << (SW - 1)) - 1);
   localparam logic signed [SUMW-1:0] SAT_MIN = -SUMW'(1 << (SW - 1));
   localparam logic signed [PW-1:0]   HALF_16 = PW'(32768);
   localparam logic signed [PW-1:0]   HALF_15 = PW'(16384);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RB,
      S_MB,
      S_FB,
      S_WR,
      S_MX,
      S_OUT
   } state_type;

   // Clamp a widened sum back into the signed sample range.
   function automatic logic signed [SW-1:0] sat(input logic signed [SUMW-1:0] v);
      logic signed [SW-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[SW-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[SW-1:0];
      end else begin
         r = v[SW-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Configuration registers. The whole delay lives in the remainder unit,
   // which holds it already reduced modulo DEPTH.
   // ---------------------------------------------------------------------
   logic [ffd_pkg::COEF_W-1:0] frac_ff;
   logic [ffd_pkg::COEF_W-1:0] mix_ff;
   logic [ffd_pkg::COEF_W-1:0] gain_ff;
   logic                       whole_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         frac_ff <= '0;
         mix_ff  <= 16'd16384;
         gain_ff <= '0;
      end else if (csr_wen) begin
         unique case (ffd_pkg::csr_index_type'(csr_addr))
            ffd_pkg::CSR_DELAY_WHOLE: begin
            end
            ffd_pkg::CSR_DELAY_FRAC: begin
               frac_ff <= csr_wdata;
            end
            ffd_pkg::CSR_MIX_LEVEL: begin
               mix_ff <= csr_wdata;
            end
            ffd_pkg::CSR_FEEDBACK_GAIN: begin
               gain_ff <= csr_wdata;
            end
         endcase
      end
   end

   assign whole_wr = csr_wen &&
                     (ffd_pkg::csr_index_type'(csr_addr) == ffd_pkg::CSR_DELAY_WHOLE);

   logic          mod_busy;
   logic [AW-1:0] delay_mod;

   ffd_delay_mod #(
      .DEPTH (DEPTH)
   ) u_delay_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (whole_wr),
      .value  (csr_wdata[ffd_pkg::WHOLE_W-1:0]),
      .busy   (mod_busy),
      .result (delay_mod)
   );

   // Gains above unity act as unity.
   logic [ffd_pkg::COEF_W-1:0] mix_c;
   logic [ffd_pkg::COEF_W-1:0] gain_c;
   logic [ffd_pkg::COEF_W-1:0] dry_c;
   logic [ffd_pkg::COEF_W:0]   inv_frac;

   assign mix_c    = (mix_ff > ffd_pkg::UNITY) ? ffd_pkg::UNITY : mix_ff;
   assign gain_c   = (gain_ff > ffd_pkg::UNITY) ? ffd_pkg::UNITY : gain_ff;
   assign dry_c    = ffd_pkg::UNITY - mix_c;
   assign inv_frac = 17'h10000 - {1'b0, frac_ff};

   // ---------------------------------------------------------------------
   // Sample store.
   // ---------------------------------------------------------------------
   logic                 st_wr_en;
   logic [AW-1:0]        st_wr_addr;
   logic signed [SW-1:0] st_wr_data;
   logic                 st_rd_en;
   logic [AW-1:0]        st_rd_addr;
   logic signed [SW-1:0] st_rd_data;
   logic                 st_clearing;

   ffd_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (st_wr_en),
      .wr_addr  (st_wr_addr),
      .wr_data  (st_wr_data),
      .rd_en    (st_rd_en),
      .rd_addr  (st_rd_addr),
      .rd_data  (st_rd_data),
      .clearing (st_clearing)
   );

   // ---------------------------------------------------------------------
   // Sequencer state and data path registers.
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [AW-1:0]         rb_ff, rb_in;
   logic signed [SW-1:0]  x_ff, x_in;
   logic                  last_ff, last_in;
   logic                  byp_ff, byp_in;
   logic signed [SW-1:0]  dl_ff, dl_in;
   logic signed [PW-1:0]  acc_ff, acc_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ffd_pkg::rsp_type      rsp_payload_ff, rsp_payload_in;

   // Shared multiplier.
   logic signed [SW-1:0]  mul_a;
   logic signed [17:0]    mul_b;
   logic signed [PW-1:0]  mul_p;

   assign mul_p = mul_a * mul_b;

   // Tap addresses: tap A sits the whole delay behind the write position,
   // tap B one entry older, both wrapping around the store.
   logic [AW:0]   diff;
   logic [AW-1:0] ra;
   logic [AW-1:0] rb;

   assign diff = {1'b0, wp_ff} - {1'b0, delay_mod};
   assign ra   = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];
   assign rb   = (ra == '0) ? AW'(DEPTH - 1) : ra - AW'(1);

   logic                  req_acc;
   logic                  bypass;
   logic signed [SUMW-1:0] fb_sum;
   logic signed [SW-1:0]   y;

   assign req_stall = !((state_ff == S_IDLE) && !st_clearing && !mod_busy);
   assign req_acc   = req_valid && !req_stall;
   assign bypass    = (delay_mod == '0);

   // Write-back value: input plus rounded feedback product.
   assign fb_sum = SUMW'(x_ff) + acc_ff[PW-1:15];

   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      rb_in          = rb_ff;
      x_in           = x_ff;
      last_in        = last_ff;
      byp_in         = byp_ff;
      dl_in          = dl_ff;
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      mul_a          = dl_ff;
      mul_b          = $signed({2'b00, mix_c});
      st_wr_en       = 1'b0;
      st_wr_addr     = wp_ff;
      st_wr_data     = sat(fb_sum);
      st_rd_en       = 1'b0;
      st_rd_addr     = rb_ff;
      y              = byp_ff ? x_ff : sat(acc_ff[PW-1:15]);

      unique case (state_ff)
         S_IDLE: begin
            // Issue the tap A read in the accept cycle.
            st_rd_addr = ra;
            if (req_acc) begin
               x_in    = req_payload.sample_in;
               last_in = req_payload.block_end;
               byp_in  = bypass;
               rb_in   = rb;
               if (bypass) begin
                  state_in = S_OUT;
               end else begin
                  st_rd_en = 1'b1;
                  state_in = S_RB;
               end
            end
         end
         S_RB: begin
            // Tap A arrives; tap B read goes out.
            st_rd_en   = 1'b1;
            st_rd_addr = rb_ff;
            mul_a      = st_rd_data;
            mul_b      = $signed({1'b0, inv_frac});
            acc_in     = mul_p;
            state_in   = S_MB;
         end
         S_MB: begin
            mul_a    = st_rd_data;
            mul_b    = $signed({2'b00, frac_ff});
            acc_in   = acc_ff + mul_p + HALF_16;
            state_in = S_FB;
         end
         S_FB: begin
            // The interpolated sample lies between the taps, so it fits.
            dl_in    = acc_ff[SW+15:16];
            mul_a    = acc_ff[SW+15:16];
            mul_b    = $signed({2'b00, gain_c});
            acc_in   = mul_p + HALF_15;
            state_in = S_WR;
         end
         S_WR: begin
            st_wr_en = 1'b1;
            wp_in    = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
            mul_a    = x_ff;
            mul_b    = $signed({2'b00, dry_c});
            acc_in   = mul_p + HALF_15;
            state_in = S_MX;
         end
         S_MX: begin
            mul_a    = dl_ff;
            mul_b    = $signed({2'b00, mix_c});
            acc_in   = acc_ff + mul_p;
            state_in = S_OUT;
         end
         S_OUT: begin
            // Load the response register once it is free or being drained.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                 = 1'b1;
               rsp_payload_in.sample_out    = y;
               rsp_payload_in.block_end_out = last_ff;
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rb_ff          <= rb_in;
      x_ff           <= x_in;
      last_ff        <= last_in;
      byp_ff         <= byp_in;
      dl_ff          <= dl_in;
      acc_ff         <= acc_in;
      rsp_payload_ff <= rsp_payload_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

[rtl/core/ffd_delay_mod.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ffd_delay_mod
// Reduces the whole delay modulo the store depth by reciprocal multiplication:
// the quotient is registered first, and the remainder follows in the next cycle.
// -----------------------------------------------------------------------------
module ffd_delay_mod #(
   parameter int DEPTH = ffd_pkg::DEPTH_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [ffd_pkg::WHOLE_W-1:0]  value,
   output logic                              busy,
   output logic [$clog2(DEPTH)-1:0]          result
);

   localparam int AW = $clog2(DEPTH);
   localparam int WW = ffd_pkg::WHOLE_W;
   // With the reciprocal rounded up and scaled by 2**SH, the truncated product
   // gives the exact quotient for every WW-bit delay.
   localparam int     SH    = WW + AW;
   localparam longint RECIP = ((longint'(1) << SH) + longint'(DEPTH - 1)) /
                              longint'(DEPTH);
   localparam int RW = WW + 2;
   localparam int PW = WW + RW;
   localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
   // The quotient is zero whenever DEPTH does not fit in WW bits, so the
   // truncated depth never takes part in the remainder then.
   localparam logic [WW-1:0] DEPTH_C = WW'(DEPTH);

   logic [1:0]    step_ff, step_in;
   logic [WW-1:0] val_ff, val_in;
   logic [WW-1:0] quot_ff, quot_in;
   logic [AW-1:0] rem_ff, rem_in;
   logic [PW-1:0] prod;
   logic [WW-1:0] back;
   logic [WW-1:0] diff;

   assign prod = {{RW{1'b0}}, val_ff} * {{WW{1'b0}}, RECIP_C};
   assign back = quot_ff * DEPTH_C;
   assign diff = val_ff - back;

   always_comb begin
      step_in = {step_ff[0], 1'b0};
      val_in  = val_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (start) begin
         step_in = 2'b01;
         val_in  = value;
      end else begin
         if (step_ff[0]) begin
            quot_in = WW'(prod >> SH);
         end
         if (step_ff[1]) begin
            rem_in = AW'(diff);
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      quot_ff <= quot_in;
      if (reset) begin
         step_ff <= '0;
         rem_ff  <= '0;
      end else begin
         step_ff <= step_in;
         rem_ff  <= rem_in;
      end
   end

   assign busy   = |step_ff;
   assign result = rem_ff;

endmodule
`default_nettype wire

[rtl/core/ffd_store.sv]
`default_nettype none
// -----------------------------------------------------------------------------
// ffd_store
// Circular sample store: one write port, one read port with registered data,
// and a clearing sweep after reset that zeroes every entry.
// -----------------------------------------------------------------------------
module ffd_store #(
   parameter int DEPTH = ffd_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  wire logic signed [ffd_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                                rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [ffd_pkg::SAMPLE_W-1:0]      rd_data,
   output logic                                     clearing
);

   localparam int AW = $clog2(DEPTH);

   logic signed [ffd_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [ffd_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                clr_busy_ff;
   logic [AW-1:0]                       clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule
`default_nettype wire

[tb/fractional_feedback_delay_tb.sv]
// -----------------------------------------------------------------------------
// fractional_feedback_delay_tb
// Self-checking bench for the mono fractional feedback delay.
// -----------------------------------------------------------------------------
// A queue of sample beats feeds a clocked driver. The driver holds each beat
// until it is taken. At each taken beat a bit-exact software copy of the delay
// line works out the mixed sample that should come back. A clocked monitor
// compares every response beat, field by field, with the oldest prediction.
// The register settings change only between phases, once the line has gone
// quiet. The settings cover pass-through, short and near-full delays, and
// mix and feedback gains at zero, at unity and above unity. Both sides pause
// at random, except in one stretch where they never pause.
// -----------------------------------------------------------------------------
module fractional_feedback_delay_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH  = 32768;
   localparam int IDLE_PCT    = 28;
   localparam int RANDOM_BEATS = 1250;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid   = 1'b0;
   logic                           req_stall;
   ffd_pkg::req_type               req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall   = 1'b0;
   ffd_pkg::rsp_type               rsp_payload;
   logic                           csr_wen     = 1'b0;
   logic [ffd_pkg::CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [ffd_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   // Beats still to be sent, and the mixed samples we are waiting to see.
   ffd_pkg::req_type samples_to_send[$];
   ffd_pkg::rsp_type awaited_outputs[$];
   ffd_pkg::rsp_type oldest_awaited;

   int  fault_count = 0;
   // While set, neither side pauses.
   bit  quiet = 1'b0;

   // Software copy of the delay line and of its register settings.
   logic signed [ffd_pkg::SAMPLE_W-1:0] echo_line [0:LINE_DEPTH-1];
   logic [ffd_pkg::WHOLE_W-1:0]         echo_head;
   logic [ffd_pkg::WHOLE_W-1:0]         tap_whole;
   logic [ffd_pkg::COEF_W-1:0]          tap_frac;
   logic [ffd_pkg::COEF_W-1:0]          wet_level;
   logic [ffd_pkg::COEF_W-1:0]          fb_gain;

   fractional_feedback_delay u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Clamp to the signed sample range.
   function automatic logic signed [ffd_pkg::SAMPLE_W-1:0] clip_sample(longint v);
      if (v > 32767) begin
         return 16'sd32767;
      end
      if (v < -32768) begin
         return -16'sd32768;
      end
      return v[ffd_pkg::SAMPLE_W-1:0];
   endfunction

   // Works out the mixed output of one sample and updates the line copy the
   // way the block updates its store.
   function automatic ffd_pkg::rsp_type mixed_output(ffd_pkg::req_type beat);
      longint x, a, b, fr, dl, g, m;
      logic [ffd_pkg::WHOLE_W-1:0] tap_a, tap_b;
      ffd_pkg::rsp_type r;
      x = beat.sample_in;
      r.block_end_out = beat.block_end;
      if (tap_whole == '0) begin
         // Zero delay: the sample passes through and the line stays as is.
         r.sample_out = beat.sample_in;
      end else begin
         // Both taps wrap around the line; tap B is one entry older.
         tap_a = echo_head - tap_whole;
         tap_b = tap_a - 1'b1;
         a  = $signed(echo_line[tap_a]);
         b  = $signed(echo_line[tap_b]);
         fr = tap_frac;
         // The arithmetic right shift of a signed value rounds toward minus
         // infinity, which is the floor that the fixed-point rules call for.
         dl = (a * (65536 - fr) + b * fr + 32768) >>> 16;
         // Gains above unity act as unity.
         g  = (fb_gain > ffd_pkg::UNITY) ? ffd_pkg::UNITY : fb_gain;
         m  = (wet_level > ffd_pkg::UNITY) ? ffd_pkg::UNITY : wet_level;
         echo_line[echo_head] = clip_sample(x + ((dl * g + 16384) >>> 15));
         echo_head = echo_head + 1'b1;
         r.sample_out = clip_sample((x * (32768 - m) + dl * m + 16384) >>> 15);
      end
      return r;
   endfunction

   // Driver: a beat stays on the bus until it is taken. The prediction is
   // made at the edge that takes it, so it sees the line as the block does.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_outputs.push_back(mixed_output(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (samples_to_send.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid   <= 1'b1;
               req_payload <= samples_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every taken response beat must match the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outputs.size() == 0) begin
               fault_count++;
               $display("%t unexpected beat: expected none, actual sample %0d end %0b",
                        $time, $signed(rsp_payload.sample_out), rsp_payload.block_end_out);
            end else begin
               oldest_awaited = awaited_outputs.pop_front();
               if (rsp_payload.sample_out !== oldest_awaited.sample_out) begin
                  fault_count++;
                  $display("%t sample_out mismatch: expected %0d, actual %0d", $time,
                           $signed(oldest_awaited.sample_out),
                           $signed(rsp_payload.sample_out));
               end
               if (rsp_payload.block_end_out !== oldest_awaited.block_end_out) begin
                  fault_count++;
                  $display("%t block_end_out mismatch: expected %0b, actual %0b", $time,
                           oldest_awaited.block_end_out, rsp_payload.block_end_out);
               end
            end
         end
         rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // One register write. The copy of the settings keeps only the bits that
   // the register holds.
   task automatic write_reg(ffd_pkg::csr_index_type idx,
                            logic [ffd_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         ffd_pkg::CSR_DELAY_WHOLE:   tap_whole = value[ffd_pkg::WHOLE_W-1:0];
         ffd_pkg::CSR_DELAY_FRAC:    tap_frac  = value;
         ffd_pkg::CSR_MIX_LEVEL:     wet_level = value;
         ffd_pkg::CSR_FEEDBACK_GAIN: fb_gain   = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic program_regs(logic [ffd_pkg::CSR_DATA_W-1:0] whole,
                               logic [ffd_pkg::CSR_DATA_W-1:0] frac,
                               logic [ffd_pkg::CSR_DATA_W-1:0] mix,
                               logic [ffd_pkg::CSR_DATA_W-1:0] gain);
      write_reg(ffd_pkg::CSR_DELAY_WHOLE, whole);
      write_reg(ffd_pkg::CSR_DELAY_FRAC, frac);
      write_reg(ffd_pkg::CSR_MIX_LEVEL, mix);
      write_reg(ffd_pkg::CSR_FEEDBACK_GAIN, gain);
   endtask

   // A gain setting: often at an edge, sometimes above unity.
   function automatic logic [ffd_pkg::CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return ffd_pkg::UNITY;
         2: return 16'($urandom_range(32769, 65535));
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   task automatic roll_settings();
      logic [ffd_pkg::CSR_DATA_W-1:0] whole, frac;
      case ($urandom_range(0, 9))
         0: whole = 16'd0;
         1: whole = 16'($urandom_range(32700, 32767));
         2: whole = 16'($urandom_range(0, 32767));
         default: whole = 16'($urandom_range(1, 24));
      endcase
      // The top data bit lies beyond the whole delay and must be dropped.
      whole[ffd_pkg::CSR_DATA_W-1] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: frac = 16'd0;
         1: frac = 16'hFFFF;
         default: frac = 16'($urandom_range(0, 65535));
      endcase
      program_regs(whole, frac, pick_gain(), pick_gain());
   endtask

   task automatic queue_sample(logic signed [ffd_pkg::SAMPLE_W-1:0] s, logic last);
      ffd_pkg::req_type beat;
      beat.sample_in = s;
      beat.block_end = last;
      samples_to_send.push_back(beat);
   endtask

   task automatic queue_random(int count);
      logic signed [ffd_pkg::SAMPLE_W-1:0] s;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 15))
            0: s = 16'sd32767;
            1: s = -16'sd32768;
            2: s = 16'sd0;
            3: s = -16'sd1;
            default: s = 16'($urandom);
         endcase
         queue_sample(s, $urandom_range(0, 5) == 0);
      end
   endtask

   // Sampled on the falling edge, away from the edges where beats move.
   task automatic wait_drained();
      @(negedge clock);
      while (samples_to_send.size() != 0 || req_valid || awaited_outputs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      int random_sent;
      int phase;
      int count;
      random_sent = 0;
      phase = 0;
      for (int i = 0; i < LINE_DEPTH; i++) begin
         echo_line[i] = '0;
      end
      echo_head = '0;
      tap_whole = '0;
      tap_frac  = '0;
      wet_level = 16'd16384;
      fb_gain   = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Settings out of reset: zero delay, so samples pass straight through.
      queue_sample(16'sd32767, 1'b0);
      queue_sample(-16'sd32768, 1'b1);
      queue_sample(16'sd0, 1'b0);
      queue_sample(-16'sd1, 1'b1);
      wait_drained();

      // One-sample delay, fully wet, unity feedback: the fed-back sum runs
      // into both rails and must saturate.
      program_regs(16'd1, 16'd0, ffd_pkg::UNITY, ffd_pkg::UNITY);
      repeat (6) queue_sample(16'sd32767, 1'b0);
      repeat (4) queue_sample(-16'sd32768, 1'b1);
      wait_drained();

      // Largest fraction, fully dry, feedback gain beyond unity.
      program_regs(16'd2, 16'hFFFF, 16'd0, 16'hFFFF);
      queue_sample(16'sd32767, 1'b0);
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(16'sd1, 1'b1);
      queue_sample(-16'sd32768, 1'b0);
      queue_sample(16'sd32767, 1'b1);
      wait_drained();

      // Longest delay, written with the spare top bit set, mix beyond unity.
      program_regs(16'hFFFF, 16'h8000, 16'hFFFF, 16'd0);
      queue_sample(16'sd12345, 1'b0);
      queue_sample(-16'sd32768, 1'b1);
      queue_sample(16'sd32767, 1'b0);
      queue_sample(-16'sd7, 1'b1);
      wait_drained();

      // Random phases, each under fresh settings.
      while (random_sent < RANDOM_BEATS) begin
         roll_settings();
         count = $urandom_range(40, 140);
         quiet = (phase == 2);
         if (phase == 4) begin
            // The sender stops halfway until the line has fully caught up.
            queue_random(count / 2);
            wait_drained();
            queue_random(count - count / 2);
         end else begin
            queue_random(count);
         end
         wait_drained();
         quiet = 1'b0;
         random_sent += count;
         phase++;
      end

      // Leave room for any stray beat to show up.
      repeat (32) @(posedge clock);
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

[fractional_feedback_delay.f]
rtl/core/ffd_pkg.sv
rtl/core/ffd_delay_mod.sv
rtl/core/ffd_store.sv
rtl/core/fractional_feedback_delay.sv
tb/fractional_feedback_delay_tb.sv
